FILE: hdl/gbn_pkg.sv
// Shared constants, request codes and control/status types of the go-back-N sender.
`default_nettype none

package gbn_pkg;

   // Default sizing handed to the top level
   localparam int WINDOW_DEF        = 5;
   localparam int MSG_DEPTH_DEF     = 1024;
   localparam int PACKET_BYTES_DEF  = 128;
   localparam int MAX_MSG_BYTES_DEF = 4096;

   // Packet header overhead and message length prefix, in bytes
   localparam int HDR_BYTES    = 7;
   localparam int PREFIX_BYTES = 4;

   // Field widths
   localparam int REQ_TYPE_W = 2;
   localparam int MSG_LEN_W  = 13;
   localparam int SEQ_W      = 32;
   localparam int OFFSET_W   = 13;
   localparam int SIZE_W     = 8;
   localparam int LEN_IN_MAX = (1 << MSG_LEN_W) - 1;

   // Stream bus widths
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 88;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_NEW     = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_ACK     = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TIMEOUT = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // capture the request beat
      logic decode;     // apply the request to queue, window and timer
      logic cut_step;   // cut one segment into the next window slot
      logic send;       // load one packet descriptor into the output register
      logic empty;      // load the flag-only result
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_ready;     // output register can take a result this cycle
      logic decode_cut;    // request cuts new segments, then sends
      logic decode_send;   // request resends the window
      logic cut_more;      // window has room and a message is queued
      logic cut_msg_done;  // the current cut finishes its message
      logic send_more;     // a packet is still to be sent
      logic send_is_last;  // the packet about to be sent is the final one
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/gbn_datapath.sv
// Datapath of the go-back-N sender: message queue, window slots, counters and output register.
`default_nettype none

module gbn_datapath #(
   parameter int WINDOW        = gbn_pkg::WINDOW_DEF,
   parameter int MSG_DEPTH     = gbn_pkg::MSG_DEPTH_DEF,
   parameter int PACKET_BYTES  = gbn_pkg::PACKET_BYTES_DEF,
   parameter int MAX_MSG_BYTES = gbn_pkg::MAX_MSG_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [gbn_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic [gbn_pkg::MSG_LEN_W-1:0]     msg_len,
   input  logic [gbn_pkg::SEQ_W-1:0]         ack_seq,
   input  logic                              ack_ok,
   input  gbn_pkg::cmd_type                  cmd,
   output gbn_pkg::status_type               status,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic                              pkt_valid,
   output logic [gbn_pkg::SEQ_W-1:0]         pkt_seq,
   output logic [gbn_pkg::SEQ_W-1:0]         msg_index,
   output logic [gbn_pkg::OFFSET_W-1:0]      seg_offset,
   output logic [gbn_pkg::SIZE_W-1:0]        seg_size,
   output logic                              timer_start,
   output logic                              timer_stop,
   output logic                              queue_full,
   output logic                              last
);

   localparam int SEG_MAX = PACKET_BYTES - gbn_pkg::HDR_BYTES;
   localparam int EFF_MAX = (MAX_MSG_BYTES < gbn_pkg::LEN_IN_MAX) ?
                            MAX_MSG_BYTES : gbn_pkg::LEN_IN_MAX;
   localparam int LEN_W   = $clog2(EFF_MAX + gbn_pkg::PREFIX_BYTES + 1);
   localparam int LIM_W   = ((LEN_W > gbn_pkg::SIZE_W) ? LEN_W : gbn_pkg::SIZE_W) + 1;
   localparam int IDX_W   = $clog2(MSG_DEPTH);
   localparam int CNT_W   = $clog2(MSG_DEPTH + 1);
   localparam int IF_W    = $clog2(WINDOW + 1);
   localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W   = $clog2(2 * WINDOW + 1);
   localparam int SQ      = gbn_pkg::SEQ_W;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      slot_inc = (s == SLOT_W'(WINDOW - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      idx_inc = (i == IDX_W'(MSG_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   // Captured request
   logic [gbn_pkg::REQ_TYPE_W-1:0] type_ff, type_in;
   logic [LEN_W-1:0]               len_ff, len_in;
   logic [SQ-1:0]                  ack_ff, ack_in;
   logic                           ok_ff, ok_in;
   logic                           start_ff, start_in;
   logic                           full_ff, full_in;

   // Queue, window and timer state
   logic [SQ-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]  head_idx_ff, head_idx_in;
   logic [IDX_W-1:0]  tail_idx_ff, tail_idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  cut_ff, cut_in;
   logic [SQ-1:0]     next_seq_ff, next_seq_in;
   logic [SQ-1:0]     send_seq_ff, send_seq_in;
   logic [SQ-1:0]     base_ff, base_in;
   logic [IF_W-1:0]   in_flight_ff, in_flight_in;
   logic [IF_W-1:0]   sent_cnt_ff, sent_cnt_in;
   logic              timer_ff, timer_in;
   logic [SLOT_W-1:0] base_slot_ff, base_slot_in;
   logic [SLOT_W-1:0] next_slot_ff, next_slot_in;
   logic [SLOT_W-1:0] send_slot_ff, send_slot_in;

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_pkt_ff, out_pkt_in;
   logic [SQ-1:0]                out_seq_ff, out_seq_in;
   logic [SQ-1:0]                out_msg_ff, out_msg_in;
   logic [gbn_pkg::OFFSET_W-1:0] out_off_ff, out_off_in;
   logic [gbn_pkg::SIZE_W-1:0]   out_size_ff, out_size_in;
   logic                         out_start_ff, out_start_in;
   logic                         out_stop_ff, out_stop_in;
   logic                         out_full_ff, out_full_in;
   logic                         out_last_ff, out_last_in;

   // Message length store and window slots
   logic [LEN_W-1:0]           len_mem [MSG_DEPTH];
   logic [LEN_W-1:0]           rd_len_ff;
   logic [SQ-1:0]              slot_msg_ff  [WINDOW];
   logic [LEN_W-1:0]           slot_off_ff  [WINDOW];
   logic [gbn_pkg::SIZE_W-1:0] slot_size_ff [WINDOW];

   logic [LEN_W-1:0]           len_sat;
   logic [SQ-1:0]              ack_dist;
   logic [IF_W-1:0]            ack_short;
   logic                       ack_inside;
   logic                       queue_open;
   logic [SUM_W-1:0]           slot_sum;
   logic [SLOT_W-1:0]          base_slot_new;
   logic [LIM_W-1:0]           cut_limit;
   logic                       seg_more;
   logic [gbn_pkg::SIZE_W-1:0] seg_len;
   logic                       stop_now;
   logic                       mem_we;

   // Saturate oversized messages
   always_comb begin
      if (32'(msg_len) > 32'(EFF_MAX)) begin
         len_sat = LEN_W'(EFF_MAX);
      end else begin
         len_sat = LEN_W'(msg_len);
      end
   end

   assign ack_dist      = ack_ff - base_ff;
   assign ack_short     = ack_dist[IF_W-1:0];
   assign ack_inside    = ok_ff && (ack_dist < SQ'(in_flight_ff));
   assign queue_open    = count_ff < CNT_W'(MSG_DEPTH);
   assign slot_sum      = SUM_W'(base_slot_ff) + SUM_W'(ack_short) + SUM_W'(1);
   assign base_slot_new = (slot_sum >= SUM_W'(WINDOW)) ?
                          SLOT_W'(slot_sum - SUM_W'(WINDOW)) : SLOT_W'(slot_sum);

   assign cut_limit = LIM_W'(cut_ff) + LIM_W'(SEG_MAX);
   assign seg_more  = LIM_W'(rd_len_ff) > cut_limit;
   assign seg_len   = seg_more ? gbn_pkg::SIZE_W'(SEG_MAX) :
                      gbn_pkg::SIZE_W'(rd_len_ff - cut_ff);

   // Stop when the ack covers the newest packet
   assign stop_now = (type_ff == gbn_pkg::REQ_ACK) && ok_ff &&
                     (ack_ff + SQ'(1) == next_seq_ff);

   assign mem_we = cmd.decode && (type_ff == gbn_pkg::REQ_NEW) && queue_open;

   assign status.out_ready    = !rsp_valid_ff || rsp_tready;
   assign status.decode_cut   = ((type_ff == gbn_pkg::REQ_NEW) && queue_open && !timer_ff) ||
                                ((type_ff == gbn_pkg::REQ_ACK) && ack_inside);
   assign status.decode_send  = (type_ff == gbn_pkg::REQ_TIMEOUT);
   assign status.cut_more     = (in_flight_ff < IF_W'(WINDOW)) && (count_ff != '0);
   assign status.cut_msg_done = !seg_more;
   assign status.send_more    = (send_seq_ff != next_seq_ff) && (sent_cnt_ff != IF_W'(WINDOW));
   assign status.send_is_last = (send_seq_ff + SQ'(1) == next_seq_ff) ||
                                (sent_cnt_ff == IF_W'(WINDOW - 1));

   always_comb begin
      type_in      = type_ff;
      len_in       = len_ff;
      ack_in       = ack_ff;
      ok_in        = ok_ff;
      start_in     = start_ff;
      full_in      = full_ff;
      head_in      = head_ff;
      head_idx_in  = head_idx_ff;
      tail_idx_in  = tail_idx_ff;
      count_in     = count_ff;
      cut_in       = cut_ff;
      next_seq_in  = next_seq_ff;
      send_seq_in  = send_seq_ff;
      base_in      = base_ff;
      in_flight_in = in_flight_ff;
      sent_cnt_in  = sent_cnt_ff;
      timer_in     = timer_ff;
      base_slot_in = base_slot_ff;
      next_slot_in = next_slot_ff;
      send_slot_in = send_slot_ff;
      out_pkt_in   = out_pkt_ff;
      out_seq_in   = out_seq_ff;
      out_msg_in   = out_msg_ff;
      out_off_in   = out_off_ff;
      out_size_in  = out_size_ff;
      out_start_in = out_start_ff;
      out_stop_in  = out_stop_ff;
      out_full_in  = out_full_ff;
      out_last_in  = out_last_ff;

      if (cmd.accept) begin
         type_in = req_type;
         len_in  = len_sat;
         ack_in  = ack_seq;
         ok_in   = ack_ok;
      end

      if (cmd.decode) begin
         sent_cnt_in = '0;
         start_in    = 1'b0;
         full_in     = 1'b0;
         case (type_ff)
            gbn_pkg::REQ_NEW: begin
               if (!queue_open) begin
                  full_in = 1'b1;
               end else begin
                  tail_idx_in = idx_inc(tail_idx_ff);
                  count_in    = count_ff + CNT_W'(1);
                  if (!timer_ff) begin
                     start_in = 1'b1;
                     timer_in = 1'b1;
                  end
               end
            end
            gbn_pkg::REQ_ACK: begin
               if (ack_inside) begin
                  start_in     = 1'b1;
                  timer_in     = 1'b1;
                  in_flight_in = in_flight_ff - ack_short - IF_W'(1);
                  base_in      = ack_ff + SQ'(1);
                  base_slot_in = base_slot_new;
               end
            end
            gbn_pkg::REQ_TIMEOUT: begin
               start_in     = 1'b1;
               timer_in     = 1'b1;
               send_seq_in  = base_ff;
               send_slot_in = base_slot_ff;
            end
            default: begin
            end
         endcase
      end

      if (cmd.cut_step) begin
         next_seq_in  = next_seq_ff + SQ'(1);
         in_flight_in = in_flight_ff + IF_W'(1);
         next_slot_in = slot_inc(next_slot_ff);
         if (seg_more) begin
            cut_in = LEN_W'(cut_limit);
         end else begin
            cut_in      = '0;
            head_in     = head_ff + SQ'(1);
            head_idx_in = idx_inc(head_idx_ff);
            count_in    = count_ff - CNT_W'(1);
         end
      end

      if (cmd.send) begin
         send_seq_in  = send_seq_ff + SQ'(1);
         send_slot_in = slot_inc(send_slot_ff);
         sent_cnt_in  = sent_cnt_ff + IF_W'(1);
         out_pkt_in   = 1'b1;
         out_seq_in   = send_seq_ff;
         out_msg_in   = slot_msg_ff[send_slot_ff];
         out_off_in   = gbn_pkg::OFFSET_W'(slot_off_ff[send_slot_ff]);
         out_size_in  = slot_size_ff[send_slot_ff];
         out_last_in  = status.send_is_last;
         out_start_in = status.send_is_last && start_ff;
         out_stop_in  = status.send_is_last && stop_now;
         out_full_in  = status.send_is_last && full_ff;
         if (status.send_is_last && stop_now) begin
            timer_in = 1'b0;
         end
      end

      if (cmd.empty) begin
         out_pkt_in   = 1'b0;
         out_seq_in   = '0;
         out_msg_in   = '0;
         out_off_in   = '0;
         out_size_in  = '0;
         out_last_in  = 1'b1;
         out_start_in = start_ff;
         out_stop_in  = stop_now;
         out_full_in  = full_ff;
         if (stop_now) begin
            timer_in = 1'b0;
         end
      end

      if (cmd.send || cmd.empty) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         head_idx_ff  <= '0;
         tail_idx_ff  <= '0;
         count_ff     <= '0;
         cut_ff       <= '0;
         next_seq_ff  <= '0;
         send_seq_ff  <= '0;
         base_ff      <= '0;
         in_flight_ff <= '0;
         sent_cnt_ff  <= '0;
         timer_ff     <= 1'b0;
         base_slot_ff <= '0;
         next_slot_ff <= '0;
         send_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         head_idx_ff  <= head_idx_in;
         tail_idx_ff  <= tail_idx_in;
         count_ff     <= count_in;
         cut_ff       <= cut_in;
         next_seq_ff  <= next_seq_in;
         send_seq_ff  <= send_seq_in;
         base_ff      <= base_in;
         in_flight_ff <= in_flight_in;
         sent_cnt_ff  <= sent_cnt_in;
         timer_ff     <= timer_in;
         base_slot_ff <= base_slot_in;
         next_slot_ff <= next_slot_in;
         send_slot_ff <= send_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      len_ff       <= len_in;
      ack_ff       <= ack_in;
      ok_ff        <= ok_in;
      start_ff     <= start_in;
      full_ff      <= full_in;
      out_pkt_ff   <= out_pkt_in;
      out_seq_ff   <= out_seq_in;
      out_msg_ff   <= out_msg_in;
      out_off_ff   <= out_off_in;
      out_size_ff  <= out_size_in;
      out_start_ff <= out_start_in;
      out_stop_ff  <= out_stop_in;
      out_full_ff  <= out_full_in;
      out_last_ff  <= out_last_in;
   end

   // Length store: write at the tail, read at the head every cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         len_mem[tail_idx_ff] <= len_ff + LEN_W'(gbn_pkg::PREFIX_BYTES);
      end
      rd_len_ff <= len_mem[head_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.cut_step) begin
         slot_msg_ff[next_slot_ff]  <= head_ff;
         slot_off_ff[next_slot_ff]  <= cut_ff;
         slot_size_ff[next_slot_ff] <= seg_len;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign pkt_valid   = out_pkt_ff;
   assign pkt_seq     = out_seq_ff;
   assign msg_index   = out_msg_ff;
   assign seg_offset  = out_off_ff;
   assign seg_size    = out_size_ff;
   assign timer_start = out_start_ff;
   assign timer_stop  = out_stop_ff;
   assign queue_full  = out_full_ff;
   assign last        = out_last_ff;

endmodule

`default_nettype wire

FILE: hdl/gbn_ctrl.sv
// Controller state machine of the go-back-N sender.
`default_nettype none

module gbn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  gbn_pkg::status_type status,
   output gbn_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DECODE   = 6'b000010,
      ST_CUT_READ = 6'b000100,
      ST_CUT_STEP = 6'b001000,
      ST_SEND     = 6'b010000,
      ST_FINAL    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (status.decode_cut) begin
               state_in = ST_CUT_READ;
            end else if (status.decode_send) begin
               state_in = ST_SEND;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_CUT_READ: begin
            // wait for the head length to come out of the store
            state_in = ST_CUT_STEP;
         end
         ST_CUT_STEP: begin
            if (status.cut_more) begin
               cmd.cut_step = 1'b1;
               if (status.cut_msg_done) begin
                  state_in = ST_CUT_READ;
               end
            end else begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (status.send_more) begin
               if (status.out_ready) begin
                  cmd.send = 1'b1;
                  if (status.send_is_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (status.out_ready) begin
               cmd.empty = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

FILE: hdl/go_back_n_sender.sv
// Top level of the go-back-N sender: controller and datapath joined by command and status.
//
// Usage: req_ takes one event per beat: a new message length, a received ack
//   (with its checksum verdict) or a timer expiry. rsp_ gives segment
//   descriptors for the packets to send; the final beat of each event carries
//   tlast and the timer start/stop and queue-full flags. An event that sends
//   nothing still gives one flag-only beat with tuser low.
// Timing: one event at a time. A flag-only event passes accept, decode and result;
//   a timeout decodes, then resends the window packet by packet (or gives one
//   flag-only result with nothing in flight). An event that cuts decodes, reads
//   the head length from the store for each message started, cuts segments into
//   free window slots until the window is full or the queue is empty, then sends
//   its packets (or one flag-only result when it sends nothing). The length
//   store read is registered; cut and send steps take one segment a cycle, and a
//   send step waits while a pending result is not taken.
// Reset: synchronous; empties the queue, zeroes the window sequence numbers, idles the
//   timer and drops any pending result. The length store is not cleared.
// Stalls: results sit in an output register; while rsp_tready is low, send and final
//   steps hold and advance only when the beat is taken. A finished last result
//   waiting there does not block acceptance of the next event.
`default_nettype none

module go_back_n_sender #(
   parameter int WINDOW        = gbn_pkg::WINDOW_DEF,
   parameter int MSG_DEPTH     = gbn_pkg::MSG_DEPTH_DEF,
   parameter int PACKET_BYTES  = gbn_pkg::PACKET_BYTES_DEF,
   parameter int MAX_MSG_BYTES = gbn_pkg::MAX_MSG_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [12:0] msg_len, [44:13] ack_seq, [47:45] zero
   input  logic [gbn_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] req_type, [2] ack_ok
   input  logic [gbn_pkg::REQ_USER_W-1:0]   req_tuser,
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] pkt_seq, [63:32] msg_index, [76:64] seg_offset, [84:77] seg_size,
   // [85] timer_start, [86] timer_stop, [87] queue_full
   output logic [gbn_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] pkt_valid
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   gbn_pkg::cmd_type    cmd;
   gbn_pkg::status_type status;

   logic [gbn_pkg::SEQ_W-1:0]    pkt_seq;
   logic [gbn_pkg::SEQ_W-1:0]    msg_index;
   logic [gbn_pkg::OFFSET_W-1:0] seg_offset;
   logic [gbn_pkg::SIZE_W-1:0]   seg_size;
   logic                         timer_start;
   logic                         timer_stop;
   logic                         queue_full;

   // Sequence the event: decode, cut segments, send the window
   gbn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Queue, window bookkeeping and the output register
   gbn_datapath #(
      .WINDOW        (WINDOW),
      .MSG_DEPTH     (MSG_DEPTH),
      .PACKET_BYTES  (PACKET_BYTES),
      .MAX_MSG_BYTES (MAX_MSG_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_type    (req_tuser[1:0]),
      .msg_len     (req_tdata[12:0]),
      .ack_seq     (req_tdata[44:13]),
      .ack_ok      (req_tuser[2]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .pkt_valid   (rsp_tuser),
      .pkt_seq     (pkt_seq),
      .msg_index   (msg_index),
      .seg_offset  (seg_offset),
      .seg_size    (seg_size),
      .timer_start (timer_start),
      .timer_stop  (timer_stop),
      .queue_full  (queue_full),
      .last        (rsp_tlast)
   );

   // Pack the descriptor, first field in the low bits
   assign rsp_tdata = {queue_full, timer_stop, timer_start, seg_size,
                       seg_offset, msg_index, pkt_seq};

endmodule

`default_nettype wire
